FILE: rtl/core/lpi_pkg.sv
// Shared widths, types and helpers for the line/plane intersection block.
`timescale 1ns / 1ps
package lpi_pkg;
  localparam int C = 32;
  localparam int F = 16;
  localparam int PW = 2 * C + 1;
  localparam int SW = 2 * C + 3;
  localparam int DW = SW + F;
  localparam int RW = SW + 1;
  localparam int XW = RW + DW;
  localparam int AW = 5;

  localparam logic [AW-3:0] REG_PX = 3'd0;
  localparam logic [AW-3:0] REG_PY = 3'd1;
  localparam logic [AW-3:0] REG_PZ = 3'd2;
  localparam logic [AW-3:0] REG_NX = 3'd3;
  localparam logic [AW-3:0] REG_NY = 3'd4;
  localparam logic [AW-3:0] REG_NZ = 3'd5;

  localparam logic [C-1:0] RST_PZ = C'(6554);
  localparam logic [C-1:0] RST_NZ = C'(65536);

  typedef struct packed {
    logic [2:0][C-1:0] a;
    logic [2:0][C:0] d;
    logic neg;
    logic zero;
  } side_t;

  function automatic logic [C-1:0] sat_sum(logic [PW:0] s);
    logic [PW-C+1:0] top;
    top = s[PW:C-1];
    if ((&top) || !(|top)) return s[C-1:0];
    return s[PW] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
  endfunction
endpackage

FILE: rtl/core/lpi_front.sv
// Dot product front end: differences, products, sums, magnitudes.
`timescale 1ns / 1ps
module lpi_front import lpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0][C-1:0] start_p,
  input  logic [2:0][C-1:0] end_p,
  input  logic [2:0][C-1:0] point,
  input  logic [2:0][C-1:0] normal,
  output logic out_valid,
  input  logic out_ready,
  output logic [DW-1:0] out_un,
  output logic [RW-1:0] out_ud,
  output side_t out_side
);
  logic [3:0] v;
  logic [4:0] en;
  logic [2:0][C-1:0] a1, a2, a3;
  logic [2:0][C:0] dp1, db1, db2, db3;
  logic [2:0][PW-1:0] pn2, pd2;
  logic [SW-1:0] num3, den3;
  logic [SW-1:0] num_c, den_c;

  always_comb begin
    en[4] = out_ready;
    for (int k = 3; k >= 0; k--) en[k] = !v[k] || en[k+1];
    num_c = '0;
    den_c = '0;
    for (int i = 0; i < 3; i++) begin
      num_c = num_c + SW'($signed(pn2[i]));
      den_c = den_c + SW'($signed(pd2[i]));
    end
  end

  assign in_ready = en[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        a1[i] <= start_p[i];
        dp1[i] <= {point[i][C-1], point[i]} - {start_p[i][C-1], start_p[i]};
        db1[i] <= {end_p[i][C-1], end_p[i]} - {start_p[i][C-1], start_p[i]};
      end
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        pn2[i] <= PW'($signed(normal[i]) * $signed(dp1[i]));
        pd2[i] <= PW'($signed(normal[i]) * $signed(db1[i]));
      end
      a2 <= a1;
      db2 <= db1;
    end
    if (en[2]) begin
      num3 <= num_c;
      den3 <= den_c;
      a3 <= a2;
      db3 <= db2;
    end
    if (en[3]) begin
      out_un <= {(num3[SW-1] ? (~num3 + SW'(1)) : num3), {F{1'b0}}};
      out_ud <= {1'b0, (den3[SW-1] ? (~den3 + SW'(1)) : den3)};
      out_side.a <= a3;
      out_side.d <= db3;
      out_side.neg <= num3[SW-1] ^ den3[SW-1];
      out_side.zero <= (den3 == '0);
    end
  end
endmodule

FILE: rtl/core/lpi_div_cell.sv
// One restoring division cell: produces one quotient bit per transfer.
`timescale 1ns / 1ps
module lpi_div_cell import lpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [XW-1:0] in_x,
  input  logic [RW-1:0] in_ud,
  input  side_t in_side,
  output logic out_valid,
  input  logic out_ready,
  output logic [XW-1:0] out_x,
  output logic [RW-1:0] out_ud,
  output side_t out_side
);
  logic [XW-1:0] s;
  logic [XW-1:0] x_next;

  always_comb begin
    s = {in_x[XW-2:0], 1'b0};
    x_next = s;
    if (s[XW-1:DW] >= in_ud) begin
      x_next[XW-1:DW] = s[XW-1:DW] - in_ud;
      x_next[0] = 1'b1;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_x <= x_next;
      out_ud <= in_ud;
      out_side <= in_side;
    end
  end
endmodule

FILE: rtl/core/lpi_back.sv
// Back end: saturate t, scale the direction, add the start, saturate.
`timescale 1ns / 1ps
module lpi_back import lpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [DW-1:0] in_q,
  input  side_t in_side,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0][C-1:0] hit,
  output logic [C-1:0] fraction,
  output logic parallel
);
  logic [2:0] v;
  logic [3:0] en;
  logic [C-1:0] t_c, t1, t2;
  side_t s1;
  logic [2:0][C-1:0] a2;
  logic [2:0][PW-1:0] pr2;
  logic z2;
  logic big;

  always_comb begin
    en[3] = out_ready;
    for (int k = 2; k >= 0; k--) en[k] = !v[k] || en[k+1];
    big = |in_q[DW-1:C-1];
    if (in_side.zero) t_c = '0;
    else if (!in_side.neg) t_c = big ? {1'b0, {(C-1){1'b1}}} : in_q[C-1:0];
    else if (big && (|in_q[DW-1:C] || |in_q[C-2:0])) t_c = {1'b1, {(C-1){1'b0}}};
    else t_c = ~in_q[C-1:0] + C'(1);
  end

  assign in_ready = en[0];
  assign out_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
    if (en[0]) begin
      t1 <= t_c;
      s1 <= in_side;
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) pr2[i] <= PW'($signed(t1) * $signed(s1.d[i]));
      a2 <= s1.a;
      t2 <= t1;
      z2 <= s1.zero;
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        hit[i] <= z2 ? a2[i]
                     : sat_sum((PW+1)'($signed(a2[i])) +
                               (PW+1)'($signed(pr2[i]) >>> F));
      end
      fraction <= t2;
      parallel <= z2;
    end
  end
endmodule

FILE: rtl/core/line_plane_intersection.sv
// Top level: configuration registers, front end, divider cell chain, back end.
`timescale 1ns / 1ps
// Segment/plane intersection in signed Q16.16. One segment is accepted per
// cycle while the pipe is not full; results pass 4 front stages, one divider
// cell per quotient bit of the 83-bit dividend, 3 back stages. Stalls on the
// output side fill the pipe stage by stage, so input keeps flowing until the
// pipe is full. Parallel segments give the start point, fraction 0, tuser 1.
module line_plane_intersection import lpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [6*C-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hit_x, hit_y, hit_z, fraction
  output logic [4*C-1:0] m_tdata,
  // parallel
  output logic [0:0] m_tuser
);
  logic [2:0][C-1:0] point, normal, start_p, end_p, hit;
  logic [C-1:0] fraction;
  logic parallel;
  logic [DW:0] cv, cr;
  logic [XW-1:0] cx [0:DW];
  logic [RW-1:0] cud [0:DW];
  side_t cs [0:DW];
  logic [DW-1:0] un;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point <= {RST_PZ, C'(0), C'(0)};
      normal <= {RST_NZ, C'(0), C'(0)};
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[AW-1:2])
        REG_PX: point[0] <= pwdata;
        REG_PY: point[1] <= pwdata;
        REG_PZ: point[2] <= pwdata;
        REG_NX: normal[0] <= pwdata;
        REG_NY: normal[1] <= pwdata;
        REG_NZ: normal[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[AW-1:2])
      REG_PX: prdata = point[0];
      REG_PY: prdata = point[1];
      REG_PZ: prdata = point[2];
      REG_NX: prdata = normal[0];
      REG_NY: prdata = normal[1];
      REG_NZ: prdata = normal[2];
      default: prdata = '0;
    endcase
  end

  assign start_p = s_tdata[3*C-1:0];
  assign end_p = s_tdata[6*C-1:3*C];

  lpi_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .start_p(start_p), .end_p(end_p), .point(point), .normal(normal),
    .out_valid(cv[0]), .out_ready(cr[0]),
    .out_un(un), .out_ud(cud[0]), .out_side(cs[0])
  );

  assign cx[0] = {{RW{1'b0}}, un};

  for (genvar k = 0; k < DW; k++) begin : g_div
    lpi_div_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(cv[k]), .in_ready(cr[k]),
      .in_x(cx[k]), .in_ud(cud[k]), .in_side(cs[k]),
      .out_valid(cv[k+1]), .out_ready(cr[k+1]),
      .out_x(cx[k+1]), .out_ud(cud[k+1]), .out_side(cs[k+1])
    );
  end

  lpi_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(cv[DW]), .in_ready(cr[DW]),
    .in_q(cx[DW][DW-1:0]), .in_side(cs[DW]),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .hit(hit), .fraction(fraction), .parallel(parallel)
  );

  assign m_tdata = {fraction, hit};
  assign m_tuser = parallel;

  a_par_frac: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[4*C-1:3*C] == '0)
    else $error("parallel result with nonzero fraction");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

  a_par_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] && (normal == '0) |-> m_tdata[4*C-1:3*C] == '0)
    else $error("zero normal result not flagged cleanly");
endmodule
